>>> rtl/msd_pkg.sv
// Shared codes, constants and helpers of the multistream segment deframer.
package msd_pkg;

    // Sub-stream count that is rejected as too many (and ids at or above it).
    localparam int MAX_STREAMS = 32;

    localparam logic [7:0] MAGIC_B0 = 8'h53;  // 'S'
    localparam logic [7:0] MAGIC_B1 = 8'h47;  // 'G'
    localparam logic [7:0] MAGIC_B2 = 8'h49;  // 'I'
    localparam logic [7:0] MAGIC_B3 = 8'h00;

    localparam logic [7:0] ID_FIELD_MASK  = 8'hf8;
    localparam logic [7:0] SRC_FIELD_MASK = 8'h07;

    localparam logic [3:0] SOURCE_LIMIT_RESET = 4'd8;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_MASK    = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_BAD_MAGIC    = 3'd0,
        ERR_TOO_MANY     = 3'd1,
        ERR_BAD_ID       = 3'd2,
        ERR_BAD_SOURCE   = 3'd3,
        ERR_RESERVED_SET = 3'd4
    } t_err;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

endpackage

>>> rtl/multistream_segment_deframer.sv
// Multistream segment deframer: byte-serial segment parser with a registered result.
//
// Input channel: one raw byte per transfer on i_data_byte (i_in_valid / o_in_ready).
// Output channel: at most one result per input byte (o_out_valid / i_out_ready):
//   a payload byte tagged with stream id, source and last flag, the received
//   stream mask with its set-bit count, an empty sub-stream marker, or an error.
// Fields that do not belong to the result kind read as zero.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the source limit
//   register; write it only while the block is idle.
// Output: a result is registered and appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while the result register is not stalled; the parse
//   step for a byte (one field update, one 32-bit decrement, a running set-bit count)
//   sits between the parser state registers and the result register.
// A stalled receiver holds the result register; a new byte is still taken in
//   the cycle the pending result is transferred. Errors drop back to the magic
//   search.
// Reset: synchronous, active low; returns to the magic search, empties the
//   result register and sets the source limit to 8.
module multistream_segment_deframer
    import msd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_stream_id,
    output logic [2:0]  o_source_code,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [31:0] o_stream_mask,
    output logic [5:0]  o_stream_count,
    output logic [2:0]  o_error_code
);

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_MASK   = 2'd1,
        PH_HEADER = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    localparam logic [5:0] MAX_STREAMS_W = 6'(MAX_STREAMS);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_asm, n_asm;
    logic [5:0]  r_cnt_acc, n_cnt_acc;
    logic [5:0]  r_streams_left, n_streams_left;
    logic [4:0]  r_cur_id, n_cur_id;
    logic [2:0]  r_cur_src, n_cur_src;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [3:0]  r_source_limit;

    logic        r_out_valid;
    t_kind       r_kind, n_kind;
    logic [4:0]  r_stream_id, n_stream_id;
    logic [2:0]  r_source_code, n_source_code;
    logic [7:0]  r_payload_byte, n_payload_byte;
    logic        r_last, n_last;
    logic [31:0] r_stream_mask, n_stream_mask;
    logic [5:0]  r_stream_count, n_stream_count;
    t_err        r_error_code, n_error_code;
    logic        n_has_result;

    logic        in_fire;
    logic [7:0]  want;
    logic [1:0]  mask_lane;
    logic [2:0]  hpos;
    logic [1:0]  len_lane;
    logic [31:0] asm_mask, asm_len;
    logic [5:0]  cnt_total;
    logic [4:0]  hdr_id;
    logic [2:0]  hdr_src;
    logic [5:0]  left_dec;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_idx[1:0])
            2'd0:    want = MAGIC_B0;
            2'd1:    want = MAGIC_B1;
            2'd2:    want = MAGIC_B2;
            default: want = MAGIC_B3;
        endcase
    end

    assign mask_lane = (r_idx > 3'd3) ? 2'd3 : r_idx[1:0];
    assign hpos      = (r_idx > 3'd5) ? 3'd5 : r_idx;
    assign len_lane  = 2'(hpos - 3'd2);
    assign asm_mask  = r_asm | (32'(i_data_byte) << {mask_lane, 3'b000});
    assign asm_len   = r_asm | (32'(i_data_byte) << {len_lane, 3'b000});
    assign cnt_total = r_cnt_acc + {2'd0, popcount8(i_data_byte)};
    assign hdr_id    = 5'((i_data_byte & ID_FIELD_MASK) >> 3);
    assign hdr_src   = 3'(i_data_byte & SRC_FIELD_MASK);
    assign left_dec  = r_streams_left - 6'd1;

    always_comb begin
        n_phase        = r_phase;
        n_idx          = r_idx;
        n_asm          = r_asm;
        n_cnt_acc      = r_cnt_acc;
        n_streams_left = r_streams_left;
        n_cur_id       = r_cur_id;
        n_cur_src      = r_cur_src;
        n_bytes_left   = r_bytes_left;
        n_has_result   = 1'b0;
        n_kind         = KIND_PAYLOAD;
        n_stream_id    = 5'd0;
        n_source_code  = 3'd0;
        n_payload_byte = 8'd0;
        n_last         = 1'b0;
        n_stream_mask  = 32'd0;
        n_stream_count = 6'd0;
        n_error_code   = ERR_BAD_MAGIC;

        unique case (r_phase)
            PH_MAGIC: begin
                if (r_idx > 3'd3 || i_data_byte != want) begin
                    n_has_result = 1'b1;
                    n_kind       = KIND_ERROR;
                    n_error_code = ERR_BAD_MAGIC;
                    n_idx        = 3'd0;
                    n_asm        = 32'd0;
                end else if (r_idx < 3'd3) begin
                    n_idx = r_idx + 3'd1;
                end else begin
                    n_phase   = PH_MASK;
                    n_idx     = 3'd0;
                    n_asm     = 32'd0;
                    n_cnt_acc = 6'd0;
                end
            end
            PH_MASK: begin
                n_asm     = asm_mask;
                n_cnt_acc = cnt_total;
                if (mask_lane != 2'd3) begin
                    n_idx = {1'b0, mask_lane} + 3'd1;
                end else if (cnt_total >= MAX_STREAMS_W) begin
                    n_has_result = 1'b1;
                    n_kind       = KIND_ERROR;
                    n_error_code = ERR_TOO_MANY;
                    n_phase      = PH_MAGIC;
                    n_idx        = 3'd0;
                    n_asm        = 32'd0;
                end else begin
                    n_has_result   = 1'b1;
                    n_kind         = KIND_MASK;
                    n_stream_mask  = asm_mask;
                    n_stream_count = cnt_total;
                    n_idx          = 3'd0;
                    n_asm          = 32'd0;
                    if (cnt_total == 6'd0) begin
                        n_phase = PH_MAGIC;
                    end else begin
                        n_streams_left = cnt_total;
                        n_phase        = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                if (hpos == 3'd0) begin
                    if ({1'b0, hdr_id} >= MAX_STREAMS_W) begin
                        n_has_result = 1'b1;
                        n_kind       = KIND_ERROR;
                        n_error_code = ERR_BAD_ID;
                        n_phase      = PH_MAGIC;
                        n_idx        = 3'd0;
                        n_asm        = 32'd0;
                    end else if ({1'b0, hdr_src} >= r_source_limit) begin
                        n_has_result = 1'b1;
                        n_kind       = KIND_ERROR;
                        n_error_code = ERR_BAD_SOURCE;
                        n_phase      = PH_MAGIC;
                        n_idx        = 3'd0;
                        n_asm        = 32'd0;
                    end else begin
                        n_cur_id  = hdr_id;
                        n_cur_src = hdr_src;
                        n_asm     = 32'd0;
                        n_idx     = 3'd1;
                    end
                end else if (hpos == 3'd1) begin
                    if (i_data_byte != 8'd0) begin
                        n_has_result = 1'b1;
                        n_kind       = KIND_ERROR;
                        n_error_code = ERR_RESERVED_SET;
                        n_phase      = PH_MAGIC;
                        n_idx        = 3'd0;
                        n_asm        = 32'd0;
                    end else begin
                        n_idx = 3'd2;
                    end
                end else if (hpos < 3'd5) begin
                    n_asm = asm_len;
                    n_idx = hpos + 3'd1;
                end else begin
                    n_bytes_left = asm_len;
                    n_idx        = 3'd0;
                    n_asm        = 32'd0;
                    if (asm_len == 32'd0) begin
                        // zero-length sub-stream: mark it and close it out
                        n_has_result   = 1'b1;
                        n_kind         = KIND_EMPTY;
                        n_stream_id    = r_cur_id;
                        n_source_code  = r_cur_src;
                        n_streams_left = left_dec;
                        n_phase        = (left_dec != 6'd0) ? PH_HEADER : PH_MAGIC;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_has_result   = 1'b1;
                n_kind         = KIND_PAYLOAD;
                n_stream_id    = r_cur_id;
                n_source_code  = r_cur_src;
                n_payload_byte = i_data_byte;
                if (r_bytes_left <= 32'd1) begin
                    n_last         = 1'b1;
                    n_bytes_left   = 32'd0;
                    n_streams_left = left_dec;
                    n_idx          = 3'd0;
                    n_asm          = 32'd0;
                    n_phase        = (left_dec != 6'd0) ? PH_HEADER : PH_MAGIC;
                end else begin
                    n_bytes_left = r_bytes_left - 32'd1;
                end
            end
            default: begin
                n_phase = PH_MAGIC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MAGIC;
            r_idx          <= 3'd0;
            r_asm          <= 32'd0;
            r_cnt_acc      <= 6'd0;
            r_streams_left <= 6'd0;
            r_cur_id       <= 5'd0;
            r_cur_src      <= 3'd0;
            r_bytes_left   <= 32'd0;
            r_source_limit <= SOURCE_LIMIT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_source_limit <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase        <= n_phase;
                r_idx          <= n_idx;
                r_asm          <= n_asm;
                r_cnt_acc      <= n_cnt_acc;
                r_streams_left <= n_streams_left;
                r_cur_id       <= n_cur_id;
                r_cur_src      <= n_cur_src;
                r_bytes_left   <= n_bytes_left;
                r_out_valid    <= n_has_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load only with a new result, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_fire && n_has_result) begin
            r_kind         <= n_kind;
            r_stream_id    <= n_stream_id;
            r_source_code  <= n_source_code;
            r_payload_byte <= n_payload_byte;
            r_last         <= n_last;
            r_stream_mask  <= n_stream_mask;
            r_stream_count <= n_stream_count;
            r_error_code   <= n_error_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_stream_id    = r_stream_id;
    assign o_source_code  = r_source_code;
    assign o_payload_byte = r_payload_byte;
    assign o_last         = r_last;
    assign o_stream_mask  = r_stream_mask;
    assign o_stream_count = r_stream_count;
    assign o_error_code   = r_error_code;

endmodule

>>> rtl/msd_checker.sv
// Port-level checks for the multistream segment deframer, bound to the top level.
module msd_checker
    import msd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [4:0]  o_stream_id,
    input logic [2:0]  o_source_code,
    input logic [7:0]  o_payload_byte,
    input logic [31:0] o_stream_mask,
    input logic [5:0]  o_stream_count,
    input logic [2:0]  o_error_code
);

    // Hold a stalled result.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_stream_mask))
        else $error("stalled result changed");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A mask result has a zero count exactly when the mask is zero.
    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_MASK
            |-> (o_stream_mask == 32'd0) == (o_stream_count == 6'd0))
        else $error("mask and count disagree");

    // An error result carries no stream tags and a known code.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERROR
            |-> o_stream_id == 5'd0 && o_source_code == 3'd0
                && o_error_code <= ERR_RESERVED_SET)
        else $error("malformed error result");

endmodule

bind multistream_segment_deframer msd_checker u_msd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_kind         (o_kind),
    .o_stream_id    (o_stream_id),
    .o_source_code  (o_source_code),
    .o_payload_byte (o_payload_byte),
    .o_stream_mask  (o_stream_mask),
    .o_stream_count (o_stream_count),
    .o_error_code   (o_error_code)
);
